// ----- rtl/kpcbc_pkg.sv -----
package kpcbc_pkg;

    localparam int unsigned TableDepth = 256;
    localparam int unsigned ByteW      = 8;
    localparam int unsigned AddrW      = $clog2(TableDepth);
    localparam int unsigned ModeW      = 3;

    // operation codes carried in the mode field
    localparam logic [ModeW-1:0] MODE_LOAD      = 3'd0;
    localparam logic [ModeW-1:0] MODE_ENC_BEGIN = 3'd1;
    localparam logic [ModeW-1:0] MODE_ENC_BYTE  = 3'd2;
    localparam logic [ModeW-1:0] MODE_DEC_BEGIN = 3'd3;
    localparam logic [ModeW-1:0] MODE_DEC_BYTE  = 3'd4;

    typedef struct packed {
        logic [ModeW-1:0] mode;
        logic [ByteW-1:0] key_index;
        logic [ByteW-1:0] key_value;
        logic [ByteW-1:0] length_low;
        logic             continue_chain;
        logic [ByteW-1:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [ByteW-1:0] result_byte;
        logic             is_tag;
    } t_out_word;

    // requests to the key/inverse table pair
    typedef struct packed {
        logic             load;      // write key[idx]=val and inv[val]=idx
        logic [AddrW-1:0] load_idx;
        logic [ByteW-1:0] load_val;
        logic             key_re;
        logic [AddrW-1:0] key_addr;
        logic             inv_re;
        logic [AddrW-1:0] inv_addr;
    } t_tbl_req;

endpackage

// ----- rtl/keyed_permutation_chained_byte_cipher.sv -----
// Channel | Direction | Handshake                  | Word
// in      | input     | i_in_valid / o_in_stall    | i_in_word  (kpcbc_pkg::t_in_word)
// out     | output    | o_out_valid / i_out_stall  | o_out_word (kpcbc_pkg::t_out_word)
//
// Steps: key load and unused modes finish in idle; byte ops, decrypt begin
//   and chained encrypt begin make one table read, unchained encrypt begin two,
//   as the synchronous table read's data sets the next address.
// Reset: synchronous, active low; clears the running index and control only.
//   Table contents are undefined until loaded.
// Stalls: a finished word waits in the output register while the next input
//   word is taken; a read result waits in the table's read register while the
//   output register is full and stalled.
module keyed_permutation_chained_byte_cipher (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  kpcbc_pkg::t_in_word   i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output kpcbc_pkg::t_out_word  o_out_word
);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;  // free to take a word
    localparam logic [1:0] ST_READ = 2'd1;  // first table read returning
    localparam logic [1:0] ST_TAG  = 2'd2;  // tag read returning

    logic [1:0]                   r_state, n_state;
    logic [kpcbc_pkg::ModeW-1:0]  r_op, n_op;
    logic [kpcbc_pkg::ByteW-1:0]  r_data, n_data;
    logic [kpcbc_pkg::ByteW-1:0]  r_t, n_t;
    logic                         r_ovalid, n_ovalid;
    kpcbc_pkg::t_out_word         r_oword, n_oword;

    kpcbc_pkg::t_tbl_req          tbl_req;
    logic [kpcbc_pkg::ByteW-1:0]  key_q;
    logic [kpcbc_pkg::ByteW-1:0]  inv_q;
    logic                         in_acc;
    logic                         out_free;

    kpcbc_tables u_tables (
        .i_clk   (i_clk),
        .i_req   (tbl_req),
        .o_key_q (key_q),
        .o_inv_q (inv_q)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    // output register can take a word this cycle
    assign out_free   = !r_ovalid || !i_out_stall;

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_data   = r_data;
        n_t      = r_t;
        n_ovalid = r_ovalid && i_out_stall;
        n_oword  = r_oword;

        tbl_req          = '0;
        tbl_req.load_idx = i_in_word.key_index;
        tbl_req.load_val = i_in_word.key_value;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_op   = i_in_word.mode;
                    n_data = i_in_word.data_byte;
                    case (i_in_word.mode)
                        kpcbc_pkg::MODE_LOAD: begin
                            tbl_req.load = 1'b1;
                        end
                        kpcbc_pkg::MODE_ENC_BEGIN: begin
                            tbl_req.key_re = 1'b1;
                            if (i_in_word.continue_chain) begin
                                // index kept: go straight to the tag read
                                tbl_req.key_addr = r_t - 8'd1;
                                n_state          = ST_TAG;
                            end else begin
                                tbl_req.key_addr = i_in_word.length_low;
                                n_state          = ST_READ;
                            end
                        end
                        kpcbc_pkg::MODE_ENC_BYTE: begin
                            tbl_req.key_re   = 1'b1;
                            tbl_req.key_addr = i_in_word.data_byte - r_t;
                            n_state          = ST_READ;
                        end
                        kpcbc_pkg::MODE_DEC_BEGIN,
                        kpcbc_pkg::MODE_DEC_BYTE: begin
                            tbl_req.inv_re   = 1'b1;
                            tbl_req.inv_addr = i_in_word.data_byte;
                            n_state          = ST_READ;
                        end
                        default: begin
                            // unused modes are dropped
                        end
                    endcase
                end
            end
            ST_READ: begin
                case (r_op)
                    kpcbc_pkg::MODE_ENC_BEGIN: begin
                        // seed index from K[len], then fetch tag K[t-1]
                        n_t              = key_q;
                        tbl_req.key_re   = 1'b1;
                        tbl_req.key_addr = key_q - 8'd1;
                        n_state          = ST_TAG;
                    end
                    kpcbc_pkg::MODE_ENC_BYTE: begin
                        if (out_free) begin
                            n_ovalid            = 1'b1;
                            n_oword.result_byte = key_q;
                            n_oword.is_tag      = 1'b0;
                            n_t                 = r_t + key_q + 8'd1;
                            n_state             = ST_IDLE;
                        end
                    end
                    kpcbc_pkg::MODE_DEC_BEGIN: begin
                        n_t     = inv_q + 8'd1;
                        n_state = ST_IDLE;
                    end
                    kpcbc_pkg::MODE_DEC_BYTE: begin
                        if (out_free) begin
                            n_ovalid            = 1'b1;
                            n_oword.result_byte = inv_q + r_t;
                            n_oword.is_tag      = 1'b0;
                            n_t                 = r_t + r_data + 8'd1;
                            n_state             = ST_IDLE;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_TAG: begin
                if (out_free) begin
                    n_ovalid            = 1'b1;
                    n_oword.result_byte = key_q;
                    n_oword.is_tag      = 1'b1;
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_t      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_t      <= n_t;
            r_ovalid <= n_ovalid;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_data  <= n_data;
        r_oword <= n_oword;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;

endmodule

// ----- rtl/kpcbc_tables.sv -----
module kpcbc_tables (
    input  logic                         i_clk,
    input  kpcbc_pkg::t_tbl_req          i_req,
    output logic [kpcbc_pkg::ByteW-1:0]  o_key_q,
    output logic [kpcbc_pkg::ByteW-1:0]  o_inv_q
);

    logic [kpcbc_pkg::ByteW-1:0] key_mem [kpcbc_pkg::TableDepth];
    logic [kpcbc_pkg::ByteW-1:0] inv_mem [kpcbc_pkg::TableDepth];
    logic [kpcbc_pkg::ByteW-1:0] r_key_q;
    logic [kpcbc_pkg::ByteW-1:0] r_inv_q;

    // read data holds until the next read enable
    always_ff @(posedge i_clk) begin
        if (i_req.load) begin
            key_mem[i_req.load_idx] <= i_req.load_val;
        end
        if (i_req.key_re) begin
            r_key_q <= key_mem[i_req.key_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.load) begin
            inv_mem[i_req.load_val] <= i_req.load_idx;
        end
        if (i_req.inv_re) begin
            r_inv_q <= inv_mem[i_req.inv_addr];
        end
    end

    assign o_key_q = r_key_q;
    assign o_inv_q = r_inv_q;

endmodule
